@@ design/cmw_pkg.sv @@
// Shared types, constants and tables for the calibration mesh warp.
`default_nettype none
package cmw_pkg;
  localparam int unsigned CoordW = 18;
  localparam int unsigned TargW  = 17;
  localparam int unsigned DiffW  = 20;
  localparam int unsigned ProdW  = 40;
  localparam int unsigned SumW   = 42;
  localparam int unsigned BlendW = 64;
  localparam int unsigned DivW   = 66;
  localparam int unsigned TriCnt = 8;

  typedef logic [3:0] vidx_t;

  function automatic vidx_t tri_vert(input logic [2:0] t, input logic [1:0] k);
    vidx_t v [0:23];
    v = '{4'd0, 4'd1, 4'd3, 4'd3, 4'd1, 4'd4, 4'd1, 4'd2, 4'd4, 4'd4, 4'd2, 4'd5,
          4'd3, 4'd4, 4'd6, 4'd6, 4'd4, 4'd7, 4'd4, 4'd5, 4'd7, 4'd7, 4'd5, 4'd8};
    return v[5'(t) * 5'd3 + 5'(k)];
  endfunction

  typedef enum logic [3:0] {
    OpIdle, OpLoadA, OpLoadB, OpLoadC, OpD1, OpD2, OpNu, OpNv, OpChk,
    OpBx, OpBy, OpDivX, OpDivY, OpOut, OpPass
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [2:0] tri_sel;
  } cmd_t;

  typedef struct packed {
    logic skip;
    logic in_tri;
    logic div_busy;
  } sts_t;
endpackage
`default_nettype wire

@@ design/cmw_datapath.sv @@
// Grid store, triangle arithmetic and shared restoring divider.
`default_nettype none
module cmw_datapath #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       acc_i,
  input  wire logic                       kind_i,
  input  wire logic [1:0]                 point_row_i,
  input  wire logic [1:0]                 point_col_i,
  input  wire logic signed [17:0]         raw_x_i,
  input  wire logic signed [17:0]         raw_y_i,
  input  wire logic [16:0]                target_x_i,
  input  wire logic [16:0]                target_y_i,
  input  wire cmw_pkg::cmd_t              cmd_i,
  output cmw_pkg::sts_t                   sts_o,
  output logic [16:0]                     res_x_o,
  output logic [16:0]                     res_y_o
);
  import cmw_pkg::*;

  localparam logic [SumW-1:0] DenMin =
    SumW'(((64'd1 << (2 * FRAC_BITS)) + 64'd999999) / 64'd1000000);
  localparam logic signed [DivW-1:0] OneV = DivW'(1) <<< FRAC_BITS;

  logic signed [CoordW-1:0] gx_q [0:8];
  logic signed [CoordW-1:0] gy_q [0:8];
  logic [TargW-1:0]         tx_q [0:8];
  logic [TargW-1:0]         ty_q [0:8];
  logic signed [CoordW-1:0] px_q, py_q;

  logic signed [CoordW-1:0] x0_q, y0_q, x1_q, y1_q, x2_q, y2_q;
  logic [TargW-1:0]         t0_q, t1_q, t2_q, s0_q, s1_q, s2_q;
  logic signed [ProdW-1:0]  pa_q, pb_q;
  logic signed [SumW-1:0]   den_q, nu_q, nv_q;
  logic signed [BlendW-1:0] bx_q, by_q;
  logic [16:0]              rx_q, ry_q;

  logic [DivW-1:0] num_q, rem_q, dvs_q;
  logic            neg_q;
  logic [6:0]      cnt_q;
  logic            busy_q;

  logic signed [DiffW-1:0] a_d, b_d, c_d, e_d, f_d, g_d;
  logic signed [SumW-1:0]  mag, nw, dn, un, vn;
  logic signed [SumW+3:0]  l5u, l5v, l5w;
  logic [2:0]              vs;
  logic [DivW:0]           trial;
  logic signed [DivW-1:0]  q, qf;

  assign a_d = DiffW'(y1_q) - DiffW'(y2_q);
  assign b_d = DiffW'(x0_q) - DiffW'(x2_q);
  assign c_d = DiffW'(x2_q) - DiffW'(x1_q);
  assign e_d = DiffW'(y0_q) - DiffW'(y2_q);
  assign f_d = DiffW'(px_q) - DiffW'(x2_q);
  assign g_d = DiffW'(py_q) - DiffW'(y2_q);

  always_comb begin
    mag = den_q[SumW-1] ? -den_q : den_q;
    dn  = mag;
    un  = den_q[SumW-1] ? -nu_q : nu_q;
    vn  = den_q[SumW-1] ? -nv_q : nv_q;
    nw  = dn - un - vn;
    l5u = 46'(un) * 46'sd5;
    l5v = 46'(vn) * 46'sd5;
    l5w = 46'(nw) * 46'sd5;
  end

  assign sts_o.skip     = mag < $signed(DenMin);
  assign sts_o.in_tri   = (l5u >= -46'(dn)) && (l5v >= -46'(dn)) && (l5w >= -46'(dn));
  assign sts_o.div_busy = busy_q;
  assign trial = {rem_q, num_q[DivW-1]} - {1'b0, dvs_q};

  always_comb begin
    q  = $signed(num_q);
    qf = neg_q ? -q - ((rem_q != '0) ? DivW'(1) : DivW'(0)) : q;
  end

  function automatic logic [16:0] clampu(input logic signed [DivW-1:0] v);
    if (v < 0) return 17'd0;
    if (v > OneV) return 17'(OneV);
    return 17'(v);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 9; i++) begin
        gx_q[i] <= '0; gy_q[i] <= '0; tx_q[i] <= '0; ty_q[i] <= '0;
      end
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (acc_i && !kind_i && point_row_i != 2'd3 && point_col_i != 2'd3) begin
        gx_q[4'(point_row_i) * 4'd3 + 4'(point_col_i)] <= raw_x_i;
        gy_q[4'(point_row_i) * 4'd3 + 4'(point_col_i)] <= raw_y_i;
        tx_q[4'(point_row_i) * 4'd3 + 4'(point_col_i)] <= target_x_i;
        ty_q[4'(point_row_i) * 4'd3 + 4'(point_col_i)] <= target_y_i;
      end
      if (busy_q) begin
        if (!trial[DivW]) rem_q <= trial[DivW-1:0];
        else rem_q <= {rem_q[DivW-2:0], num_q[DivW-1]};
        num_q <= {num_q[DivW-2:0], ~trial[DivW]};
        cnt_q <= cnt_q - 7'd1;
        if (cnt_q == 7'd1) busy_q <= 1'b0;
      end
      unique case (cmd_i.op)
        OpDivX, OpDivY: if (cmd_i.op == OpDivX || !busy_q) begin
          // floor((2s + den) / 2den); divide magnitudes, fix sign after
          // start y only once the x quotient is taken
          busy_q <= 1'b1;
          cnt_q  <= 7'(DivW);
          rem_q  <= '0;
          dvs_q  <= DivW'(dn) << 1;
          neg_q  <= (cmd_i.op == OpDivX ? bx_q : by_q) * 2 + BlendW'(dn) < 0;
          num_q  <= ((DivW'(cmd_i.op == OpDivX ? bx_q : by_q) <<< 1) + DivW'(dn)) < 0 ?
                    -((DivW'(cmd_i.op == OpDivX ? bx_q : by_q) <<< 1) + DivW'(dn)) :
                    ((DivW'(cmd_i.op == OpDivX ? bx_q : by_q) <<< 1) + DivW'(dn));
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OpIdle: if (acc_i) begin px_q <= raw_x_i; py_q <= raw_y_i; end
      OpLoadA: begin
        x0_q <= gx_q[tri_vert(cmd_i.tri_sel, 2'd0)];
        y0_q <= gy_q[tri_vert(cmd_i.tri_sel, 2'd0)];
        t0_q <= tx_q[tri_vert(cmd_i.tri_sel, 2'd0)];
        s0_q <= ty_q[tri_vert(cmd_i.tri_sel, 2'd0)];
      end
      OpLoadB: begin
        x1_q <= gx_q[tri_vert(cmd_i.tri_sel, 2'd1)];
        y1_q <= gy_q[tri_vert(cmd_i.tri_sel, 2'd1)];
        t1_q <= tx_q[tri_vert(cmd_i.tri_sel, 2'd1)];
        s1_q <= ty_q[tri_vert(cmd_i.tri_sel, 2'd1)];
      end
      OpLoadC: begin
        x2_q <= gx_q[tri_vert(cmd_i.tri_sel, 2'd2)];
        y2_q <= gy_q[tri_vert(cmd_i.tri_sel, 2'd2)];
        t2_q <= tx_q[tri_vert(cmd_i.tri_sel, 2'd2)];
        s2_q <= ty_q[tri_vert(cmd_i.tri_sel, 2'd2)];
      end
      OpD1: begin pa_q <= ProdW'(a_d) * ProdW'(b_d); pb_q <= ProdW'(c_d) * ProdW'(e_d); end
      OpD2: begin
        den_q <= SumW'(pa_q) + SumW'(pb_q);
        pa_q <= ProdW'(a_d) * ProdW'(f_d); pb_q <= ProdW'(c_d) * ProdW'(g_d);
      end
      OpNu: begin
        nu_q <= SumW'(pa_q) + SumW'(pb_q);
        pa_q <= -ProdW'(e_d) * ProdW'(f_d); pb_q <= ProdW'(b_d) * ProdW'(g_d);
      end
      OpNv: nv_q <= SumW'(pa_q) + SumW'(pb_q);
      OpBx: begin
        bx_q <= BlendW'(un) * BlendW'($signed({1'b0, t0_q})) +
                BlendW'(vn) * BlendW'($signed({1'b0, t1_q})) +
                BlendW'(nw) * BlendW'($signed({1'b0, t2_q}));
      end
      OpBy: begin
        by_q <= BlendW'(un) * BlendW'($signed({1'b0, s0_q})) +
                BlendW'(vn) * BlendW'($signed({1'b0, s1_q})) +
                BlendW'(nw) * BlendW'($signed({1'b0, s2_q}));
      end
      OpOut: if (!busy_q) ry_q <= clampu(qf);
      OpPass: begin
        rx_q <= clampu(DivW'(px_q));
        ry_q <= clampu(DivW'(py_q));
      end
      default: ;
    endcase
    if (cmd_i.op == OpDivY && busy_q == 1'b0) rx_q <= clampu(qf);
  end

  assign vs = '0;
  assign res_x_o = rx_q | 17'(vs);
  assign res_y_o = ry_q;
endmodule
`default_nettype wire

@@ design/cmw_ctrl.sv @@
// Sequencer over the eight triangles and the output handshake.
`default_nettype none
module cmw_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire logic          kind_i,
  input  wire logic          gaze_valid_i,
  input  wire cmw_pkg::sts_t sts_i,
  output cmw_pkg::cmd_t      cmd_o,
  output logic               acc_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output logic               mesh_hit_o,
  output logic [2:0]         triangle_index_o
);
  import cmw_pkg::*;

  op_e        op_q;
  logic [2:0] tri_q;
  logic       ov_q, hit_q;
  logic [2:0] idx_q;

  assign in_stall_o  = (op_q != OpIdle) || ov_q;
  assign acc_o       = in_valid_i && !in_stall_o;
  assign cmd_o.op    = op_q;
  assign cmd_o.tri_sel = tri_q;
  assign out_valid_o = ov_q;
  assign mesh_hit_o  = hit_q;
  assign triangle_index_o = idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q <= OpIdle; tri_q <= '0; ov_q <= 1'b0; hit_q <= 1'b0; idx_q <= '0;
    end else begin
      if (ov_q && !out_stall_i) ov_q <= 1'b0;
      unique case (op_q)
        OpIdle: if (acc_o && kind_i && gaze_valid_i) begin
          op_q <= OpLoadA; tri_q <= '0;
        end
        OpLoadA: op_q <= OpLoadB;
        OpLoadB: op_q <= OpLoadC;
        OpLoadC: op_q <= OpD1;
        OpD1:    op_q <= OpD2;
        OpD2:    op_q <= OpNu;
        OpNu:    op_q <= OpNv;
        OpNv:    op_q <= OpChk;
        OpChk: priority if (!sts_i.skip && sts_i.in_tri) begin
          op_q <= OpBx;
        end else if (tri_q == 3'd7) begin
          op_q <= OpPass;
        end else begin
          tri_q <= tri_q + 3'd1; op_q <= OpLoadA;
        end
        OpBx:  op_q <= OpBy;
        OpBy:  op_q <= OpDivX;
        OpDivX: op_q <= OpDivY;
        OpDivY: if (!sts_i.div_busy) op_q <= OpOut;
        OpOut: if (!sts_i.div_busy) begin
          op_q <= OpIdle; ov_q <= 1'b1; hit_q <= 1'b1; idx_q <= tri_q;
        end
        OpPass: begin
          op_q <= OpIdle; ov_q <= 1'b1; hit_q <= 1'b0; idx_q <= '0;
        end
        default: op_q <= OpIdle;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_no_acc_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_q != OpIdle) |-> !acc_o) else $error("accept while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && out_stall_i) |=> ov_q) else $error("result dropped");
  a_hit_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !hit_q) |-> (idx_q == 3'd0)) else $error("index without hit");
`endif
endmodule
`default_nettype wire

@@ design/calibration_mesh_warp.sv @@
// Each sample is tested against the triangles in turn; when a triangle matches, the
// blend and two bit-serial divisions on the shared divider (one quotient bit a cycle) follow.
// One item in flight: input stalls while a sample is processed or a result is held;
// loads and invalid samples are taken without starting the sequencer.
// Reset (rst_ni low, asynchronous) clears the grid store and the sequencer.
`default_nettype none
module calibration_mesh_warp #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        kind_i,
  input  wire logic [1:0]  point_row_i,
  input  wire logic [1:0]  point_col_i,
  input  wire logic signed [17:0] raw_x_i,
  input  wire logic signed [17:0] raw_y_i,
  input  wire logic [16:0] target_x_i,
  input  wire logic [16:0] target_y_i,
  input  wire logic        gaze_valid_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [16:0]      out_x_o,
  output logic [16:0]      out_y_o,
  output logic             mesh_hit_o,
  output logic [2:0]       triangle_index_o
);
  import cmw_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic acc;

  cmw_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .kind_i, .gaze_valid_i,
    .sts_i(sts), .cmd_o(cmd), .acc_o(acc), .out_valid_o, .out_stall_i,
    .mesh_hit_o, .triangle_index_o
  );

  cmw_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk_i, .rst_ni, .acc_i(acc), .kind_i, .point_row_i, .point_col_i,
    .raw_x_i, .raw_y_i, .target_x_i, .target_y_i, .cmd_i(cmd), .sts_o(sts),
    .res_x_o(out_x_o), .res_y_o(out_y_o)
  );
endmodule
`default_nettype wire

@@ bench/calibration_mesh_warp_tb.sv @@
// Self-checking testbench for the calibration mesh warp: grid loads and gaze samples.
`timescale 1ns / 100ps
module calibration_mesh_warp_tb;

  typedef struct {
    bit               kind;
    bit [1:0]         row;
    bit [1:0]         col;
    bit signed [17:0] rx;
    bit signed [17:0] ry;
    bit [16:0]        tx;
    bit [16:0]        ty;
    bit               gv;
    bit               drain;
  } word_t;

  typedef struct {
    bit [16:0] ox;
    bit [16:0] oy;
    bit        hit;
    bit [2:0]  tri_idx;
  } warp_t;

  localparam longint OneQ   = 64'sd65536;
  localparam longint DenMin = 64'sd4295;
  localparam int CornerOf [8][3] = '{
    '{0, 1, 3}, '{3, 1, 4}, '{1, 2, 4}, '{4, 2, 5},
    '{3, 4, 6}, '{6, 4, 7}, '{4, 5, 7}, '{7, 5, 8}
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic kind_i = 1'b0;
  logic [1:0] point_row_i = '0;
  logic [1:0] point_col_i = '0;
  logic signed [17:0] raw_x_i = '0;
  logic signed [17:0] raw_y_i = '0;
  logic [16:0] target_x_i = '0;
  logic [16:0] target_y_i = '0;
  logic gaze_valid_i = 1'b0;
  logic out_stall_i = 1'b0;
  logic in_stall_o, out_valid_o, mesh_hit_o;
  logic [16:0] out_x_o, out_y_o;
  logic [2:0] triangle_index_o;

  calibration_mesh_warp DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .kind_i, .point_row_i, .point_col_i,
    .raw_x_i, .raw_y_i, .target_x_i, .target_y_i, .gaze_valid_i,
    .out_valid_o, .out_stall_i, .out_x_o, .out_y_o, .mesh_hit_o, .triangle_index_o
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  word_t  pending_words [$];
  warp_t  expected_warps [$];
  longint mesh_meas [9][2];
  longint mesh_targ [9][2];
  int     errors = 0;
  bit     rst_done = 1'b0;
  bit     burst = 1'b0;

  function automatic longint clamp_q(longint v);
    if (v < 0) return 0;
    if (v > OneQ) return OneQ;
    return v;
  endfunction

  function automatic longint floor_q(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q--;
    return q;
  endfunction

  // Update the mesh on a load; return 1 with the mapped point on a valid sample.
  function automatic bit warp_point(input word_t w, output warp_t r);
    longint px, py, x0, y0, x1, y1, x2, y2, den, nu, nv, nw, s;
    int a, b, c, k;
    r = '{default: 0};
    if (!w.kind) begin
      if (w.row < 3 && w.col < 3) begin
        k = w.row * 3 + w.col;
        mesh_meas[k][0] = w.rx;
        mesh_meas[k][1] = w.ry;
        mesh_targ[k][0] = w.tx;
        mesh_targ[k][1] = w.ty;
      end
      return 0;
    end
    if (!w.gv) return 0;
    px = w.rx;
    py = w.ry;
    for (int t = 0; t < 8; t++) begin
      a = CornerOf[t][0]; b = CornerOf[t][1]; c = CornerOf[t][2];
      x0 = mesh_meas[a][0]; y0 = mesh_meas[a][1];
      x1 = mesh_meas[b][0]; y1 = mesh_meas[b][1];
      x2 = mesh_meas[c][0]; y2 = mesh_meas[c][1];
      den = (y1 - y2) * (x0 - x2) + (x2 - x1) * (y0 - y2);
      nu  = (y1 - y2) * (px - x2) + (x2 - x1) * (py - y2);
      nv  = (y2 - y0) * (px - x2) + (x0 - x2) * (py - y2);
      if ((den < 0 ? -den : den) < DenMin) continue;
      if (den < 0) begin
        den = -den; nu = -nu; nv = -nv;
      end
      nw = den - nu - nv;
      if (5 * nu >= -den && 5 * nv >= -den && 5 * nw >= -den) begin
        s = nu * mesh_targ[a][0] + nv * mesh_targ[b][0] + nw * mesh_targ[c][0];
        r.ox = 17'(clamp_q(floor_q(2 * s + den, 2 * den)));
        s = nu * mesh_targ[a][1] + nv * mesh_targ[b][1] + nw * mesh_targ[c][1];
        r.oy = 17'(clamp_q(floor_q(2 * s + den, 2 * den)));
        r.hit = 1'b1;
        r.tri_idx = 3'(t);
        return 1;
      end
    end
    r.ox = 17'(clamp_q(px));
    r.oy = 17'(clamp_q(py));
    return 1;
  endfunction

  function automatic word_t load_word(int r, int c, int x, int y, int tx, int ty);
    word_t w;
    w = '{kind: 0, row: 2'(r), col: 2'(c), rx: 18'(x), ry: 18'(y),
          tx: 17'(tx), ty: 17'(ty), gv: 0, drain: 0};
    return w;
  endfunction

  function automatic word_t gaze_word(int x, int y, bit gv);
    word_t w;
    w = '{kind: 1, row: 2'($urandom), col: 2'($urandom), rx: 18'(x), ry: 18'(y),
          tx: 17'($urandom), ty: 17'($urandom), gv: gv, drain: 0};
    return w;
  endfunction

  // Push a plausible calibration grid: measured points jittered around a lattice.
  task automatic push_grid();
    int jit;
    jit = $urandom_range(0, 3) == 0 ? 16'h3000 : 16'h0800;
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        pending_words.push_back(load_word(r, c,
          c * 32'h8000 + $urandom_range(0, 2 * jit) - jit,
          r * 32'h8000 + $urandom_range(0, 2 * jit) - jit,
          $urandom_range(0, 3) == 0 ? $urandom_range(0, 131071) : c * 32'h8000
            + $urandom_range(0, 2048),
          $urandom_range(0, 3) == 0 ? $urandom_range(0, 131071) : r * 32'h8000
            + $urandom_range(0, 2048)));
  endtask

  // Driver: present one word at a time, gap drawn after each acceptance.
  int    in_gap = 0;
  word_t cur;
  always @(posedge clk_i) begin
    bit    vld_next;
    warp_t r;
    vld_next = in_valid_i;
    if (rst_done) begin
      if (in_valid_i && !in_stall_o) begin
        if (warp_point(cur, r)) expected_warps.push_back(r);
        vld_next = 1'b0;
        in_gap = burst ? 0 : $urandom_range(0, 11);
      end
      if (!vld_next) begin
        if (in_gap > 0) in_gap--;
        else if (pending_words.size() > 0 &&
                 (!pending_words[0].drain || expected_warps.size() == 0)) begin
          cur = pending_words.pop_front();
          kind_i <= cur.kind;
          point_row_i <= cur.row;
          point_col_i <= cur.col;
          raw_x_i <= cur.rx;
          raw_y_i <= cur.ry;
          target_x_i <= cur.tx;
          target_y_i <= cur.ty;
          gaze_valid_i <= cur.gv;
          vld_next = 1'b1;
        end
      end
    end
    in_valid_i <= vld_next;
  end

  // Monitor: check each accepted result, then draw the next stall.
  int out_hold = 0;
  always @(posedge clk_i) begin
    warp_t e;
    if (rst_done && out_valid_o && !out_stall_i) begin
      if (expected_warps.size() == 0) begin
        $display("%0t: unexpected result x=%0d y=%0d hit=%0d tri=%0d", $realtime,
                 out_x_o, out_y_o, mesh_hit_o, triangle_index_o);
        errors++;
      end else begin
        e = expected_warps.pop_front();
        if (out_x_o !== e.ox) begin
          $display("%0t: out_x expected %0d actual %0d", $realtime, e.ox, out_x_o);
          errors++;
        end
        if (out_y_o !== e.oy) begin
          $display("%0t: out_y expected %0d actual %0d", $realtime, e.oy, out_y_o);
          errors++;
        end
        if (mesh_hit_o !== e.hit) begin
          $display("%0t: mesh_hit expected %0d actual %0d", $realtime, e.hit, mesh_hit_o);
          errors++;
        end
        if (triangle_index_o !== e.tri_idx) begin
          $display("%0t: triangle_index expected %0d actual %0d", $realtime,
                   e.tri_idx, triangle_index_o);
          errors++;
        end
      end
      out_hold = burst ? 0 : $urandom_range(0, 11);
    end
    out_stall_i <= (out_hold > 0);
    if (out_hold > 0) out_hold--;
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    word_t w;
    int    n, ngaze;
    for (int k = 0; k < 9; k++) begin
      mesh_meas[k] = '{0, 0};
      mesh_targ[k] = '{0, 0};
    end
    // Empty grid: every triangle degenerate, so raw points pass through, clamped.
    pending_words.push_back(gaze_word(-131072, 131071, 1));
    pending_words.push_back(gaze_word(131071, -131072, 1));
    pending_words.push_back(gaze_word(32768, 65536, 1));
    pending_words.push_back(gaze_word(1234, 5678, 0));
    // Bad index loads are dropped.
    pending_words.push_back(load_word(3, 1, 131071, 131071, 131071, 131071));
    pending_words.push_back(load_word(1, 3, -131072, -131072, 0, 0));
    push_grid();
    pending_words.push_back(gaze_word(32768, 32768, 1));
    pending_words.push_back(gaze_word(0, 0, 1));
    pending_words.push_back(gaze_word(65536, 65536, 1));
    pending_words.push_back(gaze_word(-20000, 30000, 1));
    pending_words.push_back(gaze_word(131071, 131071, 1));
    pending_words.push_back(gaze_word(40000, 20000, 0));
    // Targets above one are kept as given; output clamps.
    pending_words.push_back(load_word(1, 1, 32768, 32768, 131071, 131071));
    pending_words.push_back(gaze_word(32768, 32768, 1));
    pending_words.push_back(gaze_word(30000, 35000, 1));
    pending_words[pending_words.size() - 1].drain = 1'b1;
    n = 0;
    while (n < 850) begin
      if ($urandom_range(0, 9) < 7) begin
        push_grid();
        n += 9;
        ngaze = $urandom_range(10, 40);
        for (int i = 0; i < ngaze; i++) begin
          if ($urandom_range(0, 7) == 0)
            w = gaze_word($urandom, $urandom, $urandom_range(0, 3) != 0);
          else
            w = gaze_word($urandom_range(0, 90000) - 12000,
                          $urandom_range(0, 90000) - 12000, $urandom_range(0, 9) != 0);
          pending_words.push_back(w);
        end
        n += ngaze;
      end else begin
        for (int i = 0; i < 12; i++) begin
          if ($urandom_range(0, 1))
            w = load_word($urandom_range(0, 3), $urandom_range(0, 3), $urandom, $urandom,
                          $urandom, $urandom);
          else
            w = gaze_word($urandom, $urandom, $urandom_range(0, 1));
          pending_words.push_back(w);
        end
        n += 12;
      end
      if ($urandom_range(0, 4) == 0) pending_words[pending_words.size() - 1].drain = 1'b1;
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    rst_done <= 1'b1;
    while (pending_words.size() > 0 || in_valid_i) begin
      @(posedge clk_i);
      // Alternate stretches with and without idling.
      if ($urandom_range(0, 999) == 0) burst <= !burst;
    end
    while (expected_warps.size() > 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
